>>> hw/rtl/wpbe_pkg.sv
// Shared types, constants and the brightness factor table for the WS2812 bit encoder.
// Used by wpbe_front, wpbe_queue, wpbe_back and ws2812_pwm_bit_encoder_unit.
// Depends on nothing else.
package wpbe_pkg;

	localparam int BITS_PER_LED = 24;
	localparam int BIT_CNT_W    = $clog2(BITS_PER_LED + 1);
	localparam int FACTOR_W     = 17;
	localparam int FRAC_W       = 16;
	localparam int MAX_ANGLE    = 45;
	localparam int QUEUE_DEPTH  = 2;
	localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [2:0] {
		REG_BRIGHTNESS  = 3'd0,
		REG_BRIGHT_EN   = 3'd1,
		REG_HIGH_DUTY   = 3'd2,
		REG_LOW_DUTY    = 3'd3,
		REG_RESET_SLOTS = 3'd4
	} reg_idx_t;

	typedef struct packed {
		logic [5:0] brightness;
		logic       brightness_enable;
		logic [7:0] high_duty;
		logic [7:0] low_duty;
		logic [7:0] reset_slots;
	} cfg_t;

	// One LED after scaling: packed GRB word and whether it closes the frame.
	typedef struct packed {
		logic [BITS_PER_LED-1:0] word;
		logic                    frame_last;
	} job_t;

	// tan(angle degrees) in Q1.16; every angle of 45 and above gives unit scale.
	function automatic logic [FACTOR_W-1:0] tan_factor(input logic [5:0] angle);
		logic [FACTOR_W-1:0] f;
		case (angle)
			6'd0:  f = 17'd0;
			6'd1:  f = 17'd1144;
			6'd2:  f = 17'd2289;
			6'd3:  f = 17'd3435;
			6'd4:  f = 17'd4583;
			6'd5:  f = 17'd5734;
			6'd6:  f = 17'd6888;
			6'd7:  f = 17'd8047;
			6'd8:  f = 17'd9210;
			6'd9:  f = 17'd10380;
			6'd10: f = 17'd11556;
			6'd11: f = 17'd12739;
			6'd12: f = 17'd13930;
			6'd13: f = 17'd15130;
			6'd14: f = 17'd16340;
			6'd15: f = 17'd17560;
			6'd16: f = 17'd18792;
			6'd17: f = 17'd20036;
			6'd18: f = 17'd21294;
			6'd19: f = 17'd22566;
			6'd20: f = 17'd23853;
			6'd21: f = 17'd25157;
			6'd22: f = 17'd26478;
			6'd23: f = 17'd27818;
			6'd24: f = 17'd29179;
			6'd25: f = 17'd30560;
			6'd26: f = 17'd31964;
			6'd27: f = 17'd33392;
			6'd28: f = 17'd34846;
			6'd29: f = 17'd36327;
			6'd30: f = 17'd37837;
			6'd31: f = 17'd39378;
			6'd32: f = 17'd40951;
			6'd33: f = 17'd42560;
			6'd34: f = 17'd44205;
			6'd35: f = 17'd45889;
			6'd36: f = 17'd47615;
			6'd37: f = 17'd49385;
			6'd38: f = 17'd51202;
			6'd39: f = 17'd53070;
			6'd40: f = 17'd54991;
			6'd41: f = 17'd56970;
			6'd42: f = 17'd59009;
			6'd43: f = 17'd61113;
			6'd44: f = 17'd63287;
			default: f = 17'd65536;
		endcase
		return f;
	endfunction

endpackage

>>> hw/rtl/ws2812_pwm_bit_encoder_unit.sv
// Top level of the WS2812 bit encoder: configuration registers, front end, queue, back end.
// Depends on wpbe_pkg, wpbe_front, wpbe_queue and wpbe_back.
//
// Channel   Direction  Handshake            Payload
// input     in         in_valid / in_stall  red, green, blue (8 bits each)
// result    out        out_valid/ out_stall duty, repeat_res, run_last, frame_end
// config    in         wr_en                wr_index (3 bits), wr_data (8 bits)
//
// Each LED word gives 24 result words, one per cycle from the bit shifter in the back
// end while the result side does not stall, plus one reset-run word for the last LED
// of a frame. The front end scales and packs each word into its stage register, and
// with that register and the two-word queue it can hold up to three words ahead of
// the shifter.
// Reset clears the LED position and all handshake state; configuration returns to
// its documented defaults. A stall on the result side holds the output register and
// backs up through the queue to in_stall.
module ws2812_pwm_bit_encoder_unit #(
	parameter int LED_COUNT = 8
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       wr_en,
	input  logic [2:0] wr_index,
	input  logic [7:0] wr_data,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] red,
	input  logic [7:0] green,
	input  logic [7:0] blue,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] duty,
	output logic [7:0] repeat_res,
	output logic       run_last,
	output logic       frame_end
);

	wpbe_pkg::cfg_t cfg_q;
	wpbe_pkg::job_t push_job, pop_job;
	logic           push_valid, push_ready, pop_valid, pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.brightness        <= 6'd45;
			cfg_q.brightness_enable <= 1'b1;
			cfg_q.high_duty         <= 8'd60;
			cfg_q.low_duty          <= 8'd30;
			cfg_q.reset_slots       <= 8'd50;
		end else if (wr_en) begin
			case (wr_index)
				wpbe_pkg::REG_BRIGHTNESS:  cfg_q.brightness        <= wr_data[5:0];
				wpbe_pkg::REG_BRIGHT_EN:   cfg_q.brightness_enable <= wr_data[0];
				wpbe_pkg::REG_HIGH_DUTY:   cfg_q.high_duty         <= wr_data;
				wpbe_pkg::REG_LOW_DUTY:    cfg_q.low_duty          <= wr_data;
				wpbe_pkg::REG_RESET_SLOTS: cfg_q.reset_slots       <= wr_data;
				default: ;
			endcase
		end
	end

	wpbe_front #(
		.LED_COUNT(LED_COUNT)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.red        (red),
		.green      (green),
		.blue       (blue),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_job   (push_job)
	);

	wpbe_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_job   (push_job),
		.pop_valid  (pop_valid),
		.pop        (pop),
		.pop_job    (pop_job)
	);

	wpbe_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.pop_valid  (pop_valid),
		.pop        (pop),
		.pop_job    (pop_job),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.duty       (duty),
		.repeat_res (repeat_res),
		.run_last   (run_last),
		.frame_end  (frame_end)
	);

endmodule

>>> hw/rtl/wpbe_front.sv
// Front end of the WS2812 bit encoder: accepts colour words, scales and packs them,
// and tracks the LED position within the frame. Depends on wpbe_pkg.
module wpbe_front #(
	parameter int LED_COUNT = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  wpbe_pkg::cfg_t    cfg,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [7:0]        red,
	input  logic [7:0]        green,
	input  logic [7:0]        blue,
	output logic              push_valid,
	input  logic              push_ready,
	output wpbe_pkg::job_t    push_job
);

	localparam int POS_W = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;
	localparam int PROD_W = 8 + wpbe_pkg::FACTOR_W;

	logic [POS_W-1:0]              led_pos_q;
	logic                          valid_s1_q;
	wpbe_pkg::job_t                job_s1;
	logic [wpbe_pkg::FACTOR_W-1:0] factor;
	logic [PROD_W-1:0]             prod_r, prod_g, prod_b;
	logic                          accept;
	logic                          frame_last;

	// With scaling off the factor is unity, so the channel passes unchanged.
	assign factor = cfg.brightness_enable ? wpbe_pkg::tan_factor(cfg.brightness)
		: wpbe_pkg::FACTOR_W'(1 << wpbe_pkg::FRAC_W);

	assign prod_r = PROD_W'(red)   * PROD_W'(factor);
	assign prod_g = PROD_W'(green) * PROD_W'(factor);
	assign prod_b = PROD_W'(blue)  * PROD_W'(factor);

	assign frame_last = (led_pos_q == POS_W'(LED_COUNT - 1));
	assign in_stall   = valid_s1_q && !push_ready;
	assign accept     = in_valid && !in_stall;
	assign push_valid = valid_s1_q;
	assign push_job   = job_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1_q <= 1'b0;
			led_pos_q  <= '0;
		end else begin
			if (accept) begin
				valid_s1_q <= 1'b1;
				led_pos_q  <= frame_last ? '0 : led_pos_q + POS_W'(1);
			end else if (push_ready) begin
				valid_s1_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			job_s1.word <= {prod_g[23:16], prod_r[23:16], prod_b[23:16]};
			job_s1.frame_last <= frame_last;
		end
	end

endmodule

>>> hw/rtl/wpbe_queue.sv
// Short queue of packed LED words between the front and back ends of the encoder.
// Depends on wpbe_pkg.
module wpbe_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push_valid,
	output logic           push_ready,
	input  wpbe_pkg::job_t push_job,
	output logic           pop_valid,
	input  logic           pop,
	output wpbe_pkg::job_t pop_job
);

	wpbe_pkg::job_t                  entries_q [wpbe_pkg::QUEUE_DEPTH];
	logic [wpbe_pkg::QPTR_W-1:0]     wr_ptr_q, rd_ptr_q;
	logic [wpbe_pkg::QCNT_W-1:0]     count_q;
	logic                            do_push, do_pop;

	assign push_ready = (count_q != wpbe_pkg::QCNT_W'(wpbe_pkg::QUEUE_DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_job    = entries_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop && pop_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + wpbe_pkg::QPTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + wpbe_pkg::QPTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + wpbe_pkg::QCNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - wpbe_pkg::QCNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entries_q[wr_ptr_q] <= push_job;
		end
	end

endmodule

>>> hw/rtl/wpbe_back.sv
// Back end of the WS2812 bit encoder: shifts each packed word out as duty slots,
// appends the reset run at frame end, and holds the output register. Depends on wpbe_pkg.
module wpbe_back (
	input  logic           clk,
	input  logic           arst_n,
	input  wpbe_pkg::cfg_t cfg,
	input  logic           pop_valid,
	output logic           pop,
	input  wpbe_pkg::job_t pop_job,
	output logic           out_valid,
	input  logic           out_stall,
	output logic [7:0]     duty,
	output logic [7:0]     repeat_res,
	output logic           run_last,
	output logic           frame_end
);

	localparam int CW = wpbe_pkg::BIT_CNT_W;
	localparam logic [CW-1:0] LAST_BIT = CW'(wpbe_pkg::BITS_PER_LED - 1);
	localparam logic [CW-1:0] RUN_SLOT = CW'(wpbe_pkg::BITS_PER_LED);

	logic                              active_q;
	logic [wpbe_pkg::BITS_PER_LED-1:0] word_q;
	logic                              fl_q;
	logic [CW-1:0]                     cnt_q;
	logic                              out_valid_q;
	logic [7:0]                        duty_q, rep_q;
	logic                              last_q, fend_q;
	logic                              adv, emit, finishing, in_run;

	assign adv       = !out_valid_q || !out_stall;
	assign emit      = active_q && adv;
	assign in_run    = (cnt_q == RUN_SLOT);
	assign finishing = in_run || ((cnt_q == LAST_BIT) && !fl_q);
	assign pop       = pop_valid && (!active_q || (emit && finishing));

	assign out_valid  = out_valid_q;
	assign duty       = duty_q;
	assign repeat_res = rep_q;
	assign run_last   = last_q;
	assign frame_end  = fend_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q    <= 1'b0;
			out_valid_q <= 1'b0;
			cnt_q       <= '0;
		end else begin
			if (adv) begin
				out_valid_q <= active_q;
			end
			// A new word may be taken in the same cycle as the last slot of the old one.
			if (pop) begin
				active_q <= 1'b1;
				cnt_q    <= '0;
			end else if (emit) begin
				if (finishing) begin
					active_q <= 1'b0;
				end else begin
					cnt_q <= cnt_q + CW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			if (in_run) begin
				duty_q <= '0;
				rep_q  <= (cfg.reset_slots == '0) ? 8'd1 : cfg.reset_slots;
				last_q <= 1'b1;
				fend_q <= 1'b1;
			end else begin
				duty_q <= word_q[wpbe_pkg::BITS_PER_LED-1] ? cfg.high_duty : cfg.low_duty;
				rep_q  <= 8'd1;
				last_q <= (cnt_q == LAST_BIT) && !fl_q;
				fend_q <= 1'b0;
			end
		end
		if (pop) begin
			word_q <= pop_job.word;
			fl_q   <= pop_job.frame_last;
		end else if (emit && !in_run) begin
			word_q <= {word_q[wpbe_pkg::BITS_PER_LED-2:0], 1'b0};
		end
	end

`ifndef SYNTHESIS
	a_fend_closes_word: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && fend_q |-> last_q && (duty_q == '0))
		else $error("frame end word without run_last or with non-zero duty");
	a_repeat_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (rep_q != '0))
		else $error("zero repeat count on output");
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		active_q |-> (cnt_q <= RUN_SLOT))
		else $error("bit counter beyond reset slot");
	a_run_only_at_frame_end: assert property (@(posedge clk) disable iff (!arst_n)
		active_q && in_run |-> fl_q)
		else $error("reset run reached for an LED that does not close the frame");
`endif

endmodule
